FILE: rtl/bpgemv_pkg.sv
// Shared types and constants for the bitplane popcount GEMV accumulate unit.
`timescale 1ns / 1ps

package bpgemv_pkg;

  localparam int FIELD_W       = 64;
  localparam int ROW_W         = 3;
  localparam int OUT_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 2;

  localparam int ROWS_DEF      = 8;
  localparam int WORD_BITS_DEF = 64;
  localparam int ACC_BITS_DEF  = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_WEIGHTS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION_PLANES = 1'b1;

  // Item modes.
  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [ROW_W-1:0]   row;
    logic [FIELD_W-1:0] weight_word;
    logic [FIELD_W-1:0] act_plane0;
    logic [FIELD_W-1:0] act_plane1;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [OUT_W-1:0] acc_value;
  } out_item_t;

  // Control that travels with the delta from the popcount stage to the accumulators.
  typedef struct packed {
    logic             valid;
    logic             clear;
    logic [ROW_W-1:0] row;
  } acc_ctl_t;

endpackage

FILE: rtl/bpgemv_popcount.sv
// Population count of one word, counted per byte and then summed.
`timescale 1ns / 1ps

module bpgemv_popcount #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]             vec,
  output logic [$clog2(WIDTH+1)-1:0]   count
);

  localparam int CW = $clog2(WIDTH + 1);
  localparam int NB = (WIDTH + 7) / 8;

  logic [NB*8-1:0] padded;
  logic [3:0]      byte_cnt [NB];
  logic [CW-1:0]   total;

  assign padded = (NB*8)'(vec);

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(padded[b*8+k]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int b = 0; b < NB; b++) begin
      total = total + CW'(byte_cnt[b]);
    end
  end

  assign count = total;

endmodule

FILE: rtl/bpgemv_delta.sv
// Input register and popcount stage that forms each word's signed contribution.
`timescale 1ns / 1ps

module bpgemv_delta #(
  parameter int WORD_BITS = bpgemv_pkg::WORD_BITS_DEF,
  parameter int DW        = $clog2(WORD_BITS + 1) + 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bpgemv_pkg::in_item_t in_data,
  input  logic                 signed_weights,
  input  logic                 two_planes,
  output bpgemv_pkg::acc_ctl_t ctl,
  output logic [DW-1:0]        delta,
  input  logic                 ctl_ready
);
  import bpgemv_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);

  logic                 s0_valid;
  in_item_t             s0_item;
  logic                 s0_adv;
  logic                 s1_valid;
  logic                 s1_clear;
  logic [ROW_W-1:0]     s1_row;
  logic [DW-1:0]        s1_delta;
  logic                 s1_free;

  logic [WORD_BITS-1:0] w;
  logic [WORD_BITS-1:0] p0;
  logic [WORD_BITS-1:0] p1;
  logic [CW-1:0]        a0;
  logic [CW-1:0]        c0;
  logic [CW-1:0]        a1;
  logic [CW-1:0]        c1;
  logic [DW-1:0]        t0;
  logic [DW-1:0]        t1;
  logic [DW-1:0]        delta_next;

  assign s1_free  = !s1_valid || ctl_ready;
  assign s0_adv   = s0_valid && s1_free;
  assign in_ready = !s0_valid || s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item <= in_data;
    end
  end

  assign w  = s0_item.weight_word[WORD_BITS-1:0];
  assign p0 = s0_item.act_plane0[WORD_BITS-1:0];
  assign p1 = s0_item.act_plane1[WORD_BITS-1:0];

  bpgemv_popcount #(.WIDTH(WORD_BITS)) u_pc_a0 (.vec(w & p0), .count(a0));
  bpgemv_popcount #(.WIDTH(WORD_BITS)) u_pc_c0 (.vec(p0),     .count(c0));
  bpgemv_popcount #(.WIDTH(WORD_BITS)) u_pc_a1 (.vec(w & p1), .count(a1));
  bpgemv_popcount #(.WIDTH(WORD_BITS)) u_pc_c1 (.vec(p1),     .count(c1));

  // In signed mode each plane contributes matches minus mismatches, which is
  // twice the match count less the plane's own bit count.
  always_comb begin
    t0 = signed_weights ? (DW'({a0, 1'b0}) - DW'(c0)) : DW'(a0);
    t1 = signed_weights ? (DW'({a1, 1'b0}) - DW'(c1)) : DW'(a1);
    delta_next = t0 + (two_planes ? {t1[DW-2:0], 1'b0} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_clear <= (s0_item.mode == MODE_CLEAR);
      s1_row   <= s0_item.row;
      s1_delta <= delta_next;
    end
  end

  assign ctl.valid = s1_valid;
  assign ctl.clear = s1_clear;
  assign ctl.row   = s1_row;
  assign delta     = s1_delta;

endmodule

FILE: rtl/bpgemv_accbank.sv
// Row accumulators with read-modify-write update and the result register.
`timescale 1ns / 1ps

module bpgemv_accbank #(
  parameter int ROWS     = bpgemv_pkg::ROWS_DEF,
  parameter int ACC_BITS = bpgemv_pkg::ACC_BITS_DEF,
  parameter int DW       = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bpgemv_pkg::acc_ctl_t  ctl,
  input  logic [DW-1:0]         delta,
  output logic                  ctl_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bpgemv_pkg::out_item_t out_data
);
  import bpgemv_pkg::*;

  localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SUM_W = (ACC_BITS > DW) ? ACC_BITS : DW;

  logic [ACC_BITS-1:0] acc [ROWS];
  logic                fire;
  logic                clr_fire;
  logic                upd_fire;
  logic                row_ok;
  logic [RIW-1:0]      wr_idx;
  logic [SUM_W-1:0]    sum;
  logic [ACC_BITS-1:0] acc_new;
  logic                all_zero;

  assign ctl_ready = !out_valid || out_ready;
  assign fire      = ctl.valid && ctl_ready;
  assign clr_fire  = fire && ctl.clear;
  assign row_ok    = (32'(ctl.row) < ROWS);
  assign upd_fire  = fire && !ctl.clear && row_ok;
  assign wr_idx    = RIW'(ctl.row);

  // The delta is two's complement; sign-extend it before the wrapping add.
  assign sum     = SUM_W'(acc[wr_idx]) + SUM_W'(signed'(delta));
  assign acc_new = sum[ACC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst || clr_fire) begin
      for (int r = 0; r < ROWS; r++) begin
        acc[r] <= '0;
      end
    end else if (upd_fire) begin
      acc[wr_idx] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl_ready) begin
      out_valid <= upd_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_data.out_row   <= ctl.row;
      out_data.acc_value <= OUT_W'(acc_new);
    end
  end

  always_comb begin
    all_zero = 1'b1;
    for (int r = 0; r < ROWS; r++) begin
      if (acc[r] != '0) all_zero = 1'b0;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    clr_fire |=> all_zero)
    else $error("accumulators not zero after clear");

  a_update_written: assert property (@(posedge clk) disable iff (rst)
    upd_fire |=> acc[$past(wr_idx)] == $past(acc_new))
    else $error("accumulator write lost");

  a_update_result: assert property (@(posedge clk) disable iff (rst)
    upd_fire |=> out_valid && out_data.out_row == $past(ctl.row))
    else $error("result register not loaded for update");

  a_no_result_on_clear: assert property (@(posedge clk) disable iff (rst)
    clr_fire |=> !out_valid)
    else $error("clear beat produced a result");

endmodule

FILE: rtl/bitplane_popcount_gemv_accumulate_unit.sv
// An accepted input beat passes through the input, delta and result registers before its result beat is presented.
// Throughput: one input beat per cycle; input, delta and result registers each
// advance whenever the register ahead of them is empty or being drained.
// Accumulators are read, added and written back in one stage, so no forwarding.
// Reset (rst, synchronous, active high) zeroes all accumulators and empties the pipe,
// and sets signed_weights to 0 and activation_planes to 1.
`timescale 1ns / 1ps

module bitplane_popcount_gemv_accumulate_unit #(
  parameter int ROWS      = bpgemv_pkg::ROWS_DEF,
  parameter int WORD_BITS = bpgemv_pkg::WORD_BITS_DEF,
  parameter int ACC_BITS  = bpgemv_pkg::ACC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bpgemv_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bpgemv_pkg::out_item_t                out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpgemv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpgemv_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bpgemv_pkg::*;

  localparam int DW = $clog2(WORD_BITS + 1) + 3;

  logic                  signed_weights;
  logic [CFG_DATA_W-1:0] activation_planes;
  acc_ctl_t              ctl;
  logic [DW-1:0]         delta;
  logic                  ctl_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_weights    <= 1'b0;
      activation_planes <= CFG_DATA_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIGNED_WEIGHTS:    signed_weights    <= cfg_data[0];
        CFG_ACTIVATION_PLANES: activation_planes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Two planes whenever the count is two or more; zero and one both mean one.
  bpgemv_delta #(
    .WORD_BITS(WORD_BITS),
    .DW       (DW)
  ) u_delta (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .signed_weights(signed_weights),
    .two_planes    (activation_planes[1]),
    .ctl           (ctl),
    .delta         (delta),
    .ctl_ready     (ctl_ready)
  );

  bpgemv_accbank #(
    .ROWS    (ROWS),
    .ACC_BITS(ACC_BITS),
    .DW      (DW)
  ) u_accbank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .delta    (delta),
    .ctl_ready(ctl_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the bitplane popcount GEMV accumulate unit.
`timescale 1ns / 1ps

module tb_top;
  import bpgemv_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 120;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [FIELD_W-1:0] ONES = '1;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} sink_style_t;

  // One row of the directed table: either a register write or an input beat.
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_item_t              beat;
    bit                    typed;
    logic [OUT_W-1:0]      want;
  } dir_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow state of the block.
  logic [OUT_W-1:0] acc_model [ROWS_DEF];
  bit weights_signed = 1'b0;
  logic [CFG_DATA_W-1:0] plane_count = 2'd1;

  out_item_t acc_expected [$];
  dir_step_t directed [$];
  int mismatches = 0;
  bit hold_req = 1'b0;

  always #2 clk = ~clk;

  bitplane_popcount_gemv_accumulate_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int plane_sum(logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] p);
    int sum;
    sum = $countones(w & p);
    if (weights_signed) sum -= $countones(~w & p);
    return sum;
  endfunction

  // Adds the beat's exact dot product into its row and returns the wrapped total.
  function automatic logic [OUT_W-1:0] accumulate_word(in_item_t it);
    int delta;
    delta = plane_sum(it.weight_word, it.act_plane0);
    if (plane_count >= 2) delta += 2 * plane_sum(it.weight_word, it.act_plane1);
    acc_model[it.row] = acc_model[it.row] + delta[OUT_W-1:0];
    return acc_model[it.row];
  endfunction

  function automatic logic [FIELD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONES;
      2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t it;
    it.mode = ($urandom_range(0, 39) == 0) ? MODE_CLEAR : MODE_ACCUM;
    it.row = ROW_W'($urandom_range(0, ROWS_DEF - 1));
    it.weight_word = rand_word();
    it.act_plane0 = rand_word();
    it.act_plane1 = rand_word();
    return it;
  endfunction

  function automatic void add_beat(logic mode, logic [ROW_W-1:0] row, logic [FIELD_W-1:0] w,
                                   logic [FIELD_W-1:0] p0, logic [FIELD_W-1:0] p1,
                                   bit typed, logic [OUT_W-1:0] want);
    dir_step_t s;
    s = '{default: '0};
    s.beat = '{mode: mode, row: row, weight_word: w, act_plane0: p0, act_plane1: p1};
    s.typed = typed;
    s.want = want;
    directed.push_back(s);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_step_t s;
    s = '{default: '0};
    s.is_reg = 1'b1;
    s.idx = idx;
    s.val = val;
    directed.push_back(s);
  endfunction

  task automatic send_beat(input in_item_t it, input bit typed, input logic [OUT_W-1:0] want);
    out_item_t e;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (it.mode == MODE_CLEAR) begin
      foreach (acc_model[i]) acc_model[i] = '0;
    end else begin
      e.out_row = it.row;
      e.acc_value = accumulate_word(it);
      if (typed) e.acc_value = want;
      acc_expected.push_back(e);
    end
  endtask

  // Registers change only when the pipe is empty; a clear beat leaves no result
  // behind, so the extra settle wait covers one still in flight.
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    wait (acc_expected.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SIGNED_WEIGHTS) weights_signed = val[0];
    else plane_count = val;
  endtask

  task automatic flag_result(input string what, input out_item_t got, input out_item_t want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: got row %0d acc %h, expected row %0d acc %h", $realtime, what,
               got.out_row, got.acc_value, want.out_row, want.acc_value);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (acc_expected.size() == 0) begin
        flag_result("unexpected result beat", out_data, '0);
      end else begin
        want = acc_expected.pop_front();
        if (out_data.out_row !== want.out_row || out_data.acc_value !== want.acc_value)
          flag_result("result mismatch", out_data, want);
      end
    end
  end

  // The receiver changes its stall style every so often and honors one long hold-off.
  initial begin : sink
    sink_style_t style;
    int style_left;
    style = READY_ALWAYS;
    style_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (style_left == 0) begin
          style = sink_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(20, 120);
        end
        style_left--;
        case (style)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_COIN: out_ready <= 1'($urandom_range(0, 1));
          READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= style_left[1];
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] signed_set [6];
    logic [CFG_DATA_W-1:0] planes_set [6];
    int burst_left;
    bit gappy;
    signed_set = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd3, 2'd2};
    planes_set = '{2'd1, 2'd2, 2'd2, 2'd1, 2'd3, 2'd0};
    foreach (acc_model[i]) acc_model[i] = '0;

    // Directed part, starting from the reset settings: unsigned, one plane.
    add_beat(MODE_ACCUM, 3'd0, ONES, ONES, ONES, 1'b1, 16'd64);
    add_beat(MODE_ACCUM, 3'd0, ONES, ONES, ONES, 1'b1, 16'd128);
    add_beat(MODE_ACCUM, 3'd7, '0, ONES, ONES, 1'b1, 16'd0);
    add_beat(MODE_ACCUM, 3'd3, {16{4'hA}}, {16{4'h5}}, ONES, 1'b0, '0);
    add_beat(MODE_CLEAR, 3'd5, ONES, ONES, ONES, 1'b0, '0);
    add_beat(MODE_ACCUM, 3'd0, ONES, ONES, '0, 1'b1, 16'd64);
    add_reg(CFG_ACTIVATION_PLANES, 2'd2);
    add_beat(MODE_ACCUM, 3'd1, ONES, ONES, ONES, 1'b1, 16'd192);
    add_beat(MODE_ACCUM, 3'd1, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, 1'b0, '0);
    // A plane count of three behaves as two, and zero as one.
    add_reg(CFG_ACTIVATION_PLANES, 2'd3);
    add_beat(MODE_ACCUM, 3'd2, ONES, '0, ONES, 1'b1, 16'd128);
    add_reg(CFG_ACTIVATION_PLANES, 2'd0);
    add_beat(MODE_ACCUM, 3'd2, ONES, '0, ONES, 1'b1, 16'd128);
    add_reg(CFG_SIGNED_WEIGHTS, 2'd1);
    add_beat(MODE_ACCUM, 3'd4, '0, ONES, ONES, 1'b1, 16'hFFC0);
    add_beat(MODE_ACCUM, 3'd4, ONES, ONES, '0, 1'b1, 16'd0);
    add_reg(CFG_ACTIVATION_PLANES, 2'd2);
    add_beat(MODE_ACCUM, 3'd5, '0, ONES, ONES, 1'b1, 16'hFF40);
    add_beat(MODE_ACCUM, 3'd3, {8{8'h0F}}, {4{16'hFF00}}, {$urandom, $urandom}, 1'b0, '0);
    // Back to unsigned: row 5 wraps up through zero.
    add_reg(CFG_SIGNED_WEIGHTS, 2'd0);
    add_beat(MODE_ACCUM, 3'd5, ONES, ONES, ONES, 1'b1, 16'd0);
    add_beat(MODE_ACCUM, 3'd5, ONES, ONES, ONES, 1'b1, 16'd192);
    add_beat(MODE_CLEAR, 3'd0, '0, '0, '0, 1'b0, '0);
    add_beat(MODE_ACCUM, 3'd6, ONES, ONES, ONES, 1'b1, 16'd192);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_reg) program_reg(directed[i].idx, directed[i].val);
      else send_beat(directed[i].beat, directed[i].typed, directed[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 6) begin
        program_reg(CFG_SIGNED_WEIGHTS, signed_set[ph]);
        program_reg(CFG_ACTIVATION_PLANES, planes_set[ph]);
      end else begin
        program_reg(CFG_SIGNED_WEIGHTS, CFG_DATA_W'($urandom_range(0, 3)));
        program_reg(CFG_ACTIVATION_PLANES, CFG_DATA_W'($urandom_range(0, 3)));
      end
      gappy = (ph % 3 != 2);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 2 && n == 30) hold_req = 1'b1;
        if (ph == 5 && n == 60) begin
          // Let the pipe run dry before going on.
          in_valid <= 1'b0;
          wait (acc_expected.size() == 0);
          @(posedge clk);
        end else if (gappy && burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
          burst_left = $urandom_range(1, 24);
        end
        send_beat(rand_beat(), 1'b0, '0);
        if (burst_left > 0) burst_left--;
      end
    end

    in_valid <= 1'b0;
    wait (acc_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
